// File: src/prdvf_pkg.sv
// Shared types and constants for the pulse range distance/velocity filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package prdvf_pkg;

	localparam int ACC_W  = 42;
	localparam int MPL_W  = 10;
	localparam int LEN_W  = 4;
	localparam int QUOT_W = 13;

	localparam logic [LEN_W-1:0] LEN_WEIGHT = 4'd9;
	localparam logic [LEN_W-1:0] LEN_RATE   = 4'd10;

	localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(128);

	typedef enum logic [1:0] {
		ACC_ZERO,
		ACC_HALF,
		ACC_KEEP
	} acc_init_t;

	typedef struct packed {
		logic             start;
		acc_init_t        init;
		logic [LEN_W-1:0] len;
	} mac_cmd_t;

	typedef enum logic [1:0] {
		REG_MIN_WIDTH  = 2'd0,
		REG_MAX_WIDTH  = 2'd1,
		REG_ALPHA      = 2'd2,
		REG_RATE       = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL_AD,
		ST_MUL_BD,
		ST_MUL_RATE,
		ST_MUL_AV,
		ST_MUL_BV
	} state_t;

endpackage

`default_nettype wire

// File: src/prdvf_div10.sv
// Bit-serial restoring divider by ten: one quotient bit per cycle.
// Depends on prdvf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prdvf_div10 (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [15:0]                   dividend,
	output logic                               busy,
	output logic [prdvf_pkg::QUOT_W-1:0]       quot
);
	import prdvf_pkg::*;

	localparam logic [4:0] DIVISOR = 5'd10;

	logic              busy_q;
	logic [3:0]        cnt_q;
	logic [15:0]       dvd_q;
	logic [3:0]        rem_q;
	logic [QUOT_W-1:0] quot_q;

	logic [4:0] trial;
	logic       qbit;
	logic [3:0] rem_next;
	logic [4:0] trial_sub;

	assign trial     = {rem_q, dvd_q[15]};
	assign qbit      = (trial >= DIVISOR);
	assign trial_sub = trial - DIVISOR;
	assign rem_next  = qbit ? trial_sub[3:0] : trial[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'd15;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 4'd1;
			busy_q <= (cnt_q != 4'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[14:0], 1'b0};
			rem_q  <= rem_next;
			quot_q <= {quot_q[QUOT_W-2:0], qbit};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

`ifndef SYNTHESIS
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < 4'd10))
		else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

// File: src/prdvf_mac.sv
// Serial-parallel multiply-accumulate: one multiplier bit per cycle, shared
// by every product of the filter. Depends on prdvf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prdvf_mac (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire prdvf_pkg::mac_cmd_t                 cmd,
	input  wire logic signed [prdvf_pkg::ACC_W-1:0]  mcand,
	input  wire logic [prdvf_pkg::MPL_W-1:0]         mplier,
	output logic                                     busy,
	output logic signed [prdvf_pkg::ACC_W-1:0]       acc
);
	import prdvf_pkg::*;

	logic                    busy_q;
	logic [LEN_W-1:0]        cnt_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] mcand_q;
	logic [MPL_W-1:0]        mplier_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= cmd.len;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - LEN_W'(1);
			busy_q <= (cnt_q != LEN_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			unique case (cmd.init)
				ACC_ZERO: acc_q <= '0;
				ACC_HALF: acc_q <= ROUND_HALF;
				ACC_KEEP: acc_q <= acc_q;
				default:  acc_q <= acc_q;
			endcase
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign busy = busy_q;
	assign acc  = acc_q;

`ifndef SYNTHESIS
	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q)
		else $error("mac started while busy");

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0))
		else $error("mac busy with empty count");
`endif

endmodule

`default_nettype wire

// File: src/pulse_range_distance_velocity_filter.sv
// Each word passes through the serial divide-by-ten (16 bits) and five bit-serial
// products of 9, 9, 10, 9 and 9 multiplier bits on one MAC; a new word is taken
// only once the last one has finished.
// A result word waiting on the output stalls only the final step of the next word.
// Reset clears the filter state to zero and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module pulse_range_distance_velocity_filter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] pulse_width_us,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [23:0]      distance_cm_q8,
	output logic signed [31:0] velocity_cms_q8,
	output logic             width_rejected,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import prdvf_pkg::*;

	localparam logic signed [ACC_W-1:0] S32_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [ACC_W-1:0] S32_MIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
		logic signed [31:0] r;
		if (x > S32_MAX) begin
			r = 32'sh7fffffff;
		end else if (x < S32_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	state_t state_q, state_d;

	logic [15:0]        min_q;
	logic [15:0]        max_q;
	logic [8:0]         alpha_q;
	logic [9:0]         rate_q;
	logic [QUOT_W-1:0]  held_q;
	logic [23:0]        dist_q;
	logic signed [31:0] vel_q;
	logic               rej_q;
	logic signed [31:0] vel_raw_q;

	logic               out_valid_q;
	logic [23:0]        out_dist_q;
	logic signed [31:0] out_vel_q;
	logic               out_rej_q;

	logic               div_start;
	logic               div_busy;
	logic [QUOT_W-1:0]  div_quot;

	mac_cmd_t                mac_cmd;
	logic signed [ACC_W-1:0] mac_mcand;
	logic [MPL_W-1:0]        mac_mplier;
	logic                    mac_busy;
	logic signed [ACC_W-1:0] mac_acc;

	logic [8:0]         alpha_sat;
	logic [8:0]         beta;
	logic [15:0]        width_q10;
	logic               rejected;
	logic [23:0]        new_dist;
	logic signed [24:0] dist_diff;
	logic [20:0]        dist_in;
	logic signed [ACC_W-1:0] acc_shr;
	logic signed [31:0] vel_raw;
	logic signed [31:0] new_vel;
	logic               finish;

	prdvf_div10 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (pulse_width_us),
		.busy     (div_busy),
		.quot     (div_quot)
	);

	prdvf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.mcand  (mac_mcand),
		.mplier (mac_mplier),
		.busy   (mac_busy),
		.acc    (mac_acc)
	);

	assign alpha_sat = alpha_q[8] ? 9'd256 : alpha_q;
	assign beta      = 9'd256 - alpha_sat;
	assign width_q10 = {div_quot, 3'b000} + {2'b00, div_quot, 1'b0};
	assign rejected  = (width_q10 < min_q) || (width_q10 > max_q);
	assign new_dist  = mac_acc[31:8];
	assign dist_diff = $signed({1'b0, new_dist}) - $signed({1'b0, dist_q});
	assign dist_in   = {held_q, 8'b0};
	assign acc_shr   = mac_acc >>> 8;
	assign vel_raw   = sat32(mac_acc);
	assign new_vel   = sat32(acc_shr);

	always_comb begin
		state_d    = state_q;
		div_start  = 1'b0;
		finish     = 1'b0;
		mac_cmd    = '{start: 1'b0, init: ACC_KEEP, len: '0};
		mac_mcand  = '0;
		mac_mplier = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!div_busy) begin
					mac_cmd    = '{start: 1'b1, init: ACC_HALF, len: LEN_WEIGHT};
					mac_mcand  = {{(ACC_W-24){1'b0}}, dist_q};
					mac_mplier = MPL_W'(alpha_sat);
					state_d    = ST_MUL_AD;
				end
			end
			ST_MUL_AD: begin
				if (!mac_busy) begin
					mac_cmd    = '{start: 1'b1, init: ACC_KEEP, len: LEN_WEIGHT};
					mac_mcand  = {{(ACC_W-21){1'b0}}, dist_in};
					mac_mplier = MPL_W'(beta);
					state_d    = ST_MUL_BD;
				end
			end
			ST_MUL_BD: begin
				if (!mac_busy) begin
					mac_cmd    = '{start: 1'b1, init: ACC_ZERO, len: LEN_RATE};
					mac_mcand  = {{(ACC_W-25){dist_diff[24]}}, dist_diff};
					mac_mplier = rate_q;
					state_d    = ST_MUL_RATE;
				end
			end
			ST_MUL_RATE: begin
				if (!mac_busy) begin
					mac_cmd    = '{start: 1'b1, init: ACC_HALF, len: LEN_WEIGHT};
					mac_mcand  = {{(ACC_W-32){vel_q[31]}}, vel_q};
					mac_mplier = MPL_W'(alpha_sat);
					state_d    = ST_MUL_AV;
				end
			end
			ST_MUL_AV: begin
				if (!mac_busy) begin
					// raw velocity goes in as saturated 32-bit value
					mac_cmd    = '{start: 1'b1, init: ACC_KEEP, len: LEN_WEIGHT};
					mac_mcand  = {{(ACC_W-32){vel_raw_q[31]}}, vel_raw_q};
					mac_mplier = MPL_W'(beta);
					state_d    = ST_MUL_BV;
				end
			end
			ST_MUL_BV: begin
				if (!mac_busy && (!out_valid_q || out_ready)) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= 16'd0;
			max_q       <= 16'd40000;
			alpha_q     <= 9'd90;
			rate_q      <= 10'd100;
			held_q      <= '0;
			dist_q      <= '0;
			vel_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MIN_WIDTH: min_q   <= cfg_data;
					REG_MAX_WIDTH: max_q   <= cfg_data;
					REG_ALPHA:     alpha_q <= cfg_data[8:0];
					REG_RATE:      rate_q  <= cfg_data[9:0];
					default: ;
				endcase
			end
			if ((state_q == ST_DIV) && !div_busy && !rejected) begin
				held_q <= div_quot;
			end
			if ((state_q == ST_MUL_BD) && !mac_busy) begin
				dist_q <= new_dist;
			end
			if (finish) begin
				vel_q       <= new_vel;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && !div_busy) begin
			rej_q <= rejected;
		end
		// rate product is overwritten by the next MAC start, keep it here
		if ((state_q == ST_MUL_RATE) && !mac_busy) begin
			vel_raw_q <= vel_raw;
		end
		if (finish) begin
			out_dist_q <= dist_q;
			out_vel_q  <= new_vel;
			out_rej_q  <= rej_q;
		end
	end

	assign in_ready        = (state_q == ST_IDLE);
	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign distance_cm_q8  = out_dist_q;
	assign velocity_cms_q8 = out_vel_q;
	assign width_rejected  = out_rej_q;

`ifndef SYNTHESIS
	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> ((state_q == ST_DIV) && div_busy))
		else $error("accepted word did not start the divider");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_busy && mac_busy))
		else $error("divider and mac busy together");

	a_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_MUL_BV) && out_valid_q && !out_ready) |=> (state_q == ST_MUL_BV))
		else $error("result finished over a pending word");
`endif

endmodule

`default_nettype wire

// File: sim/tb.sv
// Testbench for pulse_range_distance_velocity_filter: directed and random pulse widths
// under changing register settings, checked word by word against a built-in predictor.
// Depends on src/prdvf_pkg.sv and src/pulse_range_distance_velocity_filter.sv.
`timescale 1ns / 1ps

module tb;
	import prdvf_pkg::*;

	localparam int HALF_PERIOD    = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 8;
	localparam int PHASE_WORDS    = 200;
	localparam longint VEL_MAX    = 64'sd2147483647;
	localparam longint VEL_MIN    = -64'sd2147483648;

	typedef struct {
		logic [23:0]        distance;
		logic signed [31:0] velocity;
		logic               rejected;
	} reading_t;

	class range_filter_scoreboard;
		logic [15:0]        min_width;
		logic [15:0]        max_width;
		logic [8:0]         alpha;
		logic [9:0]         rate;
		logic [15:0]        held_width;
		logic [23:0]        distance;
		logic signed [31:0] velocity;
		reading_t           expected_readings[$];
		int                 errors;
		int                 readings_checked;

		function new();
			min_width        = 16'd0;
			max_width        = 16'd40000;
			alpha            = 9'd90;
			rate             = 10'd100;
			held_width       = 16'd0;
			distance         = 24'd0;
			velocity         = 32'sd0;
			errors           = 0;
			readings_checked = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [15:0] data);
			case (idx)
				REG_MIN_WIDTH: min_width = data;
				REG_MAX_WIDTH: max_width = data;
				REG_ALPHA:     alpha = data[8:0];
				REG_RATE:      rate = data[9:0];
				default: ;
			endcase
		endfunction

		static function longint clamp32(longint x);
			if (x > VEL_MAX)
				return VEL_MAX;
			if (x < VEL_MIN)
				return VEL_MIN;
			return x;
		endfunction

		// quantize, gate, then two Q8 moving averages rounding half up
		function void note_input(logic [15:0] width);
			longint   q, a, b, prev_d, d_in, new_d, v_raw, new_v;
			reading_t r;
			q = (longint'(width) / 10) * 10;
			r.rejected = (q < longint'(min_width)) || (q > longint'(max_width));
			if (!r.rejected)
				held_width = q[15:0];
			a = (alpha > 9'd256) ? 256 : longint'(alpha);
			b = 256 - a;
			prev_d = longint'(distance);
			d_in = (longint'(held_width) / 10) << 8;
			new_d = (a * prev_d + b * d_in + 128) >>> 8;
			if (new_d < 0)
				new_d = 0;
			if (new_d > 64'sd16777215)
				new_d = 64'sd16777215;
			v_raw = clamp32((new_d - prev_d) * longint'(rate));
			new_v = clamp32((a * longint'(velocity) + b * v_raw + 128) >>> 8);
			distance = new_d[23:0];
			velocity = new_v[31:0];
			r.distance = distance;
			r.velocity = velocity;
			expected_readings.push_back(r);
		endfunction

		function void check_result(logic [23:0] d, logic signed [31:0] v, logic rej);
			reading_t e;
			if (expected_readings.size() == 0) begin
				$error("result word with nothing expected: distance %0d velocity %0d", d, v);
				errors++;
				return;
			end
			e = expected_readings.pop_front();
			readings_checked++;
			if (d !== e.distance) begin
				$error("distance_cm_q8: expected %0d, got %0d", e.distance, d);
				errors++;
			end
			if (v !== e.velocity) begin
				$error("velocity_cms_q8: expected %0d, got %0d", e.velocity, v);
				errors++;
			end
			if (rej !== e.rejected) begin
				$error("width_rejected: expected %0b, got %0b", e.rejected, rej);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [15:0]        pulse_width_us = 16'd0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [23:0]        distance_cm_q8;
	logic signed [31:0] velocity_cms_q8;
	logic               width_rejected;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	reg_idx_t           cfg_index = REG_MIN_WIDTH;
	logic [15:0]        cfg_data = 16'd0;

	logic               steady = 1'b0;
	logic [15:0]        stall_pattern = 16'hFFFF;
	logic [5:0]         sink_age = 6'd0;
	int                 stalled_cycles = 0;
	int                 words_sent = 0;
	int                 burst_left = 0;
	range_filter_scoreboard sb;

	always #(HALF_PERIOD) clk = ~clk;

	pulse_range_distance_velocity_filter dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.pulse_width_us  (pulse_width_us),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.distance_cm_q8  (distance_cm_q8),
		.velocity_cms_q8 (velocity_cms_q8),
		.width_rejected  (width_rejected),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// sink stalls on a rotating mask, re-drawn whenever the six-bit age counter wraps
	always @(posedge clk) begin
		sink_age <= sink_age + 6'd1;
		if (steady) begin
			out_ready <= 1'b1;
		end else if (sink_age == 6'd0) begin
			stall_pattern <= ($urandom_range(3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
			out_ready <= 1'b1;
		end else begin
			stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
			out_ready <= stall_pattern[15];
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(distance_cm_q8, velocity_cms_q8, width_rejected);
			if (in_valid && in_ready)
				sb.note_input(pulse_width_us);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles > WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_word(input logic [15:0] width);
		int gap;
		in_valid <= 1'b1;
		pulse_width_us <= width;
		do
			@(posedge clk);
		while (!in_ready);
		words_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else if (!steady) begin
			case ($urandom_range(3))
				0: gap = 0;
				1: gap = $urandom_range(8, 1);
				2: gap = $urandom_range(40, 9);
				default: gap = $urandom_range(100, 41);
			endcase
			burst_left = ($urandom_range(4) == 0) ? 40 : $urandom_range(12, 1);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// wait for every word in flight to come back
	task automatic settle(input int pause);
		in_valid <= 1'b0;
		while (sb.readings_checked < words_sent)
			@(posedge clk);
		repeat (pause) @(posedge clk);
	endtask

	task automatic set_regs(input logic [15:0] min_w, input logic [15:0] max_w,
			input logic [15:0] alpha_w, input logic [15:0] rate_w, input bit [3:0] which);
		logic [15:0] vals [4];
		vals = '{min_w, max_w, alpha_w, rate_w};
		for (int k = 0; k < 4; k++) begin
			if (which[k]) begin
				cfg_valid <= 1'b1;
				cfg_index <= reg_idx_t'(k);
				cfg_data <= vals[k];
				do
					@(posedge clk);
				while (!cfg_ready);
			end
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_width(int lo, int hi);
		int e;
		case ($urandom_range(7))
			0, 1: return 16'($urandom);
			2: begin
				e = ($urandom_range(1) == 1) ? lo : hi;
				e = e + int'($urandom_range(30)) - 15;
				if (e < 0)
					e = 0;
				if (e > 65535)
					e = 65535;
				return 16'(e);
			end
			default: begin
				if (lo <= hi)
					return 16'($urandom_range(hi, lo));
				return 16'($urandom);
			end
		endcase
	endfunction

	initial begin
		logic [15:0] min_w, max_w, alpha_w, rate_w, tmp;
		logic [15:0] opening [11];
		sb = new();
		opening = '{16'd65535, 16'd0, 16'd9, 16'd10, 16'd19, 16'd39999, 16'd40000,
			16'd40009, 16'd40010, 16'hAAAA, 16'h5555};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// defaults; the first word is rejected before any width was held
		foreach (opening[k])
			send_word(opening[k]);
		settle(4);
		// minimum above maximum
		set_regs(16'd500, 16'd400, 16'd0, 16'd0, 4'b0011);
		send_word(16'd450);
		send_word(16'd1000);
		settle(4);
		set_regs(16'd0, 16'd65535, 16'd0, 16'd1023, 4'b1111);
		send_word(16'd65535);
		send_word(16'd0);
		settle(4);
		set_regs(16'd0, 16'd0, 16'd256, 16'd0, 4'b0100);
		send_word(16'd30000);
		send_word(16'd100);
		settle(4);
		// alpha past full scale freezes both averages; zero rate
		set_regs(16'd0, 16'd0, 16'hFFFF, 16'd0, 4'b1100);
		send_word(16'd5000);
		send_word(16'd60000);
		settle(4);
		set_regs(16'd0, 16'd0, 16'd128, 16'd0, 4'b0100);
		send_word(16'd20000);
		send_word(16'd700);
		settle(4);

		for (int p = 0; p < PHASES; p++) begin
			case ($urandom_range(9))
				0, 1, 2: min_w = 16'd0;
				3: min_w = 16'hFFFF;
				default: min_w = 16'($urandom);
			endcase
			case ($urandom_range(9))
				0, 1, 2: max_w = 16'hFFFF;
				3: max_w = 16'd0;
				default: max_w = 16'($urandom);
			endcase
			if (min_w > max_w && $urandom_range(4) != 0) begin
				tmp = min_w;
				min_w = max_w;
				max_w = tmp;
			end
			case ($urandom_range(9))
				0: alpha_w = 16'd0;
				1: alpha_w = 16'd256;
				2: alpha_w = 16'($urandom_range(511, 257));
				default: alpha_w = 16'($urandom_range(256));
			endcase
			case ($urandom_range(9))
				0: rate_w = 16'd0;
				1: rate_w = 16'd1023;
				2: rate_w = 16'd1;
				3: rate_w = 16'd1000;
				default: rate_w = 16'($urandom_range(1000, 1));
			endcase
			if ($urandom_range(3) == 0)
				alpha_w[15:9] = 7'($urandom);
			if ($urandom_range(3) == 0)
				rate_w[15:10] = 6'($urandom);
			set_regs(min_w, max_w, alpha_w, rate_w, 4'b1111);
			steady <= (p % 4 == 3);
			for (int n = 0; n < PHASE_WORDS; n++)
				send_word(pick_width(int'(min_w), int'(max_w)));
			settle(4);
		end

		settle(80);
		if (sb.expected_readings.size() != 0) begin
			$error("%0d expected readings never arrived", sb.expected_readings.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
